// File: rtl/core/crhi_pkg.sv
// ----------------------------------------------------------------------------
// crhi_pkg - shared constants of the chained hash record index
// Transaction kinds, result status codes and default sizes.
// ----------------------------------------------------------------------------
package crhi_pkg;

	localparam int BUCKETS_DEF    = 20;
	localparam int CAPACITY_DEF   = 64;
	localparam int CODE_BYTES_DEF = 4;

	// most results one search may emit
	localparam int MAX_OUT = 64;

	// hash unit operand width
	localparam int HVW = 16;

	// transaction kinds
	localparam logic [1:0] K_INSERT = 2'd0;
	localparam logic [1:0] K_NUMBER = 2'd1;
	localparam logic [1:0] K_ORIGIN = 2'd2;
	localparam logic [1:0] K_DEST   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_STORED  = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MATCH   = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	// index selectors
	localparam logic [1:0] IX_NUM = 2'd0;
	localparam logic [1:0] IX_ORG = 2'd1;
	localparam logic [1:0] IX_DST = 2'd2;

endpackage

// File: rtl/core/crhi_hash.sv
// ----------------------------------------------------------------------------
// crhi_hash - bucket reduction unit
// Reduces a 16-bit value modulo BUCKETS by reciprocal multiplication: the
// quotient is registered while start is high, the remainder in the cycle after.
// ----------------------------------------------------------------------------
module crhi_hash
	import crhi_pkg::*;
#(
	parameter int BUCKETS = BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [HVW-1:0]             value,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bucket
);

	localparam int BW = $clog2(BUCKETS);
	localparam int SH = HVW + BW;
	localparam int MW = HVW + 2;
	localparam int PW = HVW + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

	logic [PW-1:0]  prod;
	logic [HVW-1:0] v_s1;
	logic [HVW-1:0] q_s1;
	logic           run_s1;
	logic           done_q;
	logic [HVW-1:0] r_q;

	// estimate the quotient with the rounded-up reciprocal
	assign prod = {{MW{1'b0}}, value} * {{HVW{1'b0}}, RECIP};

	// advance the two reduction steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_s1 <= start;
			done_q <= run_s1;
		end
	end

	// hold the operand and quotient, then form the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			v_s1 <= value;
			q_s1 <= HVW'(prod >> SH);
		end
		if (run_s1) begin
			r_q <= v_s1 - HVW'(q_s1 * HVW'(BUCKETS));
		end
	end

	assign done   = done_q;
	assign bucket = r_q[BW-1:0];

endmodule

// File: rtl/core/crhi_store.sv
// ----------------------------------------------------------------------------
// crhi_store - record and chain link memories
// Two synchronous single-port-write memories with registered read data.
// ----------------------------------------------------------------------------
module crhi_store
	import crhi_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int RW       = 102,
	parameter int LW       = 21
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] waddr,
	input  logic [RW-1:0]         wrec,
	input  logic [LW-1:0]         wlink,
	input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] raddr,
	output logic [RW-1:0]         rrec,
	output logic [LW-1:0]         rlink
);

	logic [RW-1:0] rec_mem  [CAPACITY];
	logic [LW-1:0] link_mem [CAPACITY];
	logic [RW-1:0] rrec_q;
	logic [LW-1:0] rlink_q;

	// write a new slot
	always_ff @(posedge clk) begin
		if (we) begin
			rec_mem[waddr]  <= wrec;
			link_mem[waddr] <= wlink;
		end
	end

	// read with registered data
	always_ff @(posedge clk) begin
		rrec_q  <= rec_mem[raddr];
		rlink_q <= link_mem[raddr];
	end

	assign rrec  = rrec_q;
	assign rlink = rlink_q;

endmodule

// File: rtl/core/chained_hash_record_index_top.sv
// ----------------------------------------------------------------------------
// chained_hash_record_index_top - record store with three hash chains
// An insert runs three bucket reductions (start, multiply, done) through the
// shared hash unit, one per index, then a write state; a refused insert is
// answered from the idle state. A search hashes its key and looks up the
// bucket head, then walks the chain with a memory read and then a compare per
// record, one more read step at the chain end and a flush step that shows the
// final result (the walk stops early at the 64th match). Results come at most
// one per cycle with done high and cannot be held off; busy is high from
// acceptance until the cycle in which the final result is shown.
// Matches are given newest first, the final one with last set; a search
// without match gives one no-match.
// ----------------------------------------------------------------------------
module chained_hash_record_index_top
	import crhi_pkg::*;
#(
	parameter int BUCKETS    = BUCKETS_DEF,
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int CODE_BYTES = CODE_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              kind,
	input  logic [15:0]             flight_number,
	input  logic [8*CODE_BYTES-1:0] origin_code,
	input  logic [2:0]              origin_length,
	input  logic [8*CODE_BYTES-1:0] dest_code,
	input  logic [2:0]              dest_length,
	input  logic [15:0]             duration,
	output logic                    done,
	output logic [1:0]              status,
	output logic [15:0]             match_number,
	output logic [8*CODE_BYTES-1:0] match_origin,
	output logic [2:0]              match_origin_length,
	output logic [8*CODE_BYTES-1:0] match_dest,
	output logic [2:0]              match_dest_length,
	output logic [15:0]             match_duration,
	output logic                    last
);

	localparam int CW  = 8 * CODE_BYTES;
	localparam int BW  = $clog2(BUCKETS);
	localparam int AW  = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
	localparam int NW  = $clog2(CAPACITY + 1);
	localparam int OW  = $clog2(MAX_OUT + 1);
	localparam int RW  = 16 + CW + 3 + CW + 3 + 16;
	localparam int LE  = AW + 1;
	localparam int LW  = 3 * LE;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HASH  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_CMP   = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;
	localparam logic [2:0] S_WR    = 3'd5;

	function automatic logic [2:0] clamp_len(input logic [2:0] len);
		return (int'(len) > CODE_BYTES) ? 3'(CODE_BYTES) : len;
	endfunction

	function automatic logic [CW-1:0] prep_code(input logic [CW-1:0] code,
			input logic [2:0] len, input logic up);
		logic [CW-1:0] r;
		logic [7:0]    b;
		r = '0;
		for (int i = 0; i < CODE_BYTES; i++) begin
			b = code[8*i +: 8];
			if (up && b >= 8'h61 && b <= 8'h7a) begin
				b = b - 8'h20;
			end
			if (i < int'(len)) begin
				r[8*i +: 8] = b;
			end
		end
		return r;
	endfunction

	function automatic logic [HVW-1:0] byte_sum(input logic [CW-1:0] code);
		logic [HVW-1:0] s;
		s = '0;
		for (int i = 0; i < CODE_BYTES; i++) begin
			s = s + HVW'(code[8*i +: 8]);
		end
		return s;
	endfunction

	logic [2:0]     state_q;
	logic [1:0]     kind_q;
	logic [15:0]    num_q;
	logic [CW-1:0]  org_q;
	logic [2:0]     olen_q;
	logic [CW-1:0]  dst_q;
	logic [2:0]     dlen_q;
	logic [15:0]    dur_q;
	logic [1:0]     hsel_q;
	logic           hstart_q;
	logic [BW-1:0]  bkt_q [3];
	logic [NW-1:0]  count_q;
	logic [AW-1:0]  head_slot_q [3][BUCKETS];
	logic           head_ok_q   [3][BUCKETS];
	logic [AW-1:0]  slot_q;
	logic           ok_q;
	logic [OW-1:0]  n_q;
	logic           pend_v_q;
	logic [RW-1:0]  pend_q;

	logic           done_q;
	logic [1:0]     status_q;
	logic [RW-1:0]  res_q;
	logic           last_q;

	logic           accept;
	logic [2:0]     in_olen;
	logic [2:0]     in_dlen;
	logic [1:0]     cur_ix;
	logic [HVW-1:0] hval;
	logic           hdone;
	logic [BW-1:0]  hbkt;
	logic           we;
	logic [RW-1:0]  wrec;
	logic [LW-1:0]  wlink;
	logic [RW-1:0]  rrec;
	logic [LW-1:0]  rlink;
	logic           hit;
	logic [LE-1:0]  nlink;

	assign accept  = start && !busy;
	assign in_olen = clamp_len(origin_length);
	assign in_dlen = clamp_len(dest_length);
	assign cur_ix  = (kind_q == K_INSERT) ? hsel_q : kind_q - 2'd1;

	// pick the operand of the hash unit
	always_comb begin
		unique case (cur_ix)
			IX_NUM:  hval = num_q;
			IX_ORG:  hval = byte_sum(org_q);
			default: hval = byte_sum(dst_q);
		endcase
	end

	crhi_hash #(.BUCKETS(BUCKETS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hstart_q),
		.value  (hval),
		.done   (hdone),
		.bucket (hbkt)
	);

	// build the new record and its links
	assign we   = (state_q == S_WR);
	assign wrec = {num_q, org_q, olen_q, dst_q, dlen_q, dur_q};
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wlink[i*LE +: LE] = {head_ok_q[i][bkt_q[i]], head_slot_q[i][bkt_q[i]]};
		end
	end

	crhi_store #(.CAPACITY(CAPACITY), .RW(RW), .LW(LW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[AW-1:0]),
		.wrec  (wrec),
		.wlink (wlink),
		.raddr (slot_q),
		.rrec  (rrec),
		.rlink (rlink)
	);

	// compare the fetched record with the query
	always_comb begin
		unique case (cur_ix)
			IX_NUM: hit = (rrec[RW-1 -: 16] == num_q);
			IX_ORG: hit = (rrec[RW-17 -: CW] == org_q) && (rrec[RW-17-CW -: 3] == olen_q);
			default: hit = (rrec[18+CW -: CW] == dst_q) && (rrec[16 +: 3] == dlen_q);
		endcase
		nlink = rlink[cur_ix*LE +: LE];
	end

	// sequence inserts and chain walks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hstart_q <= 1'b0;
			count_q  <= '0;
			pend_v_q <= 1'b0;
			done_q   <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int b = 0; b < BUCKETS; b++) begin
					head_ok_q[i][b] <= 1'b0;
				end
			end
		end else begin
			hstart_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == K_INSERT && int'(count_q) == CAPACITY) begin
							done_q <= 1'b1;
						end else begin
							hstart_q <= 1'b1;
							state_q  <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hdone) begin
						bkt_q[hsel_q] <= hbkt;
						if (kind_q == K_INSERT) begin
							if (hsel_q == IX_DST) begin
								state_q <= S_WR;
							end else begin
								hstart_q <= 1'b1;
							end
						end else begin
							slot_q  <= head_slot_q[cur_ix][hbkt];
							ok_q    <= head_ok_q[cur_ix][hbkt];
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					state_q <= ok_q ? S_CMP : S_FLUSH;
				end
				S_CMP: begin
					slot_q  <= nlink[AW-1:0];
					ok_q    <= nlink[AW];
					state_q <= S_WALK;
					if (hit) begin
						if (pend_v_q) begin
							done_q <= 1'b1;
						end
						pend_v_q <= 1'b1;
						if (int'(n_q) == MAX_OUT - 1) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					done_q   <= 1'b1;
					pend_v_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				S_WR: begin
					for (int i = 0; i < 3; i++) begin
						head_ok_q[i][bkt_q[i]] <= 1'b1;
					end
					count_q <= count_q + 1'b1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold transaction fields, head slots and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			kind_q <= kind;
			num_q  <= flight_number;
			olen_q <= in_olen;
			dlen_q <= in_dlen;
			dur_q  <= duration;
			org_q  <= prep_code(origin_code, in_olen, kind == K_ORIGIN);
			dst_q  <= prep_code(dest_code, in_dlen, kind == K_DEST);
			hsel_q <= IX_NUM;
			n_q    <= '0;
			status_q <= ST_FULL;
			res_q    <= '0;
			last_q   <= 1'b1;
		end
		if (state_q == S_HASH && hdone) begin
			hsel_q <= hsel_q + 2'd1;
		end
		if (state_q == S_CMP && hit) begin
			pend_q   <= rrec;
			n_q      <= n_q + 1'b1;
			status_q <= ST_MATCH;
			res_q    <= pend_q;
			last_q   <= 1'b0;
		end
		if (state_q == S_FLUSH) begin
			status_q <= pend_v_q ? ST_MATCH : ST_NOMATCH;
			res_q    <= pend_v_q ? pend_q : '0;
			last_q   <= 1'b1;
		end
		if (state_q == S_WR) begin
			for (int i = 0; i < 3; i++) begin
				head_slot_q[i][bkt_q[i]] <= count_q[AW-1:0];
			end
			status_q <= ST_STORED;
			res_q    <= '0;
			last_q   <= 1'b1;
		end
	end

	assign busy                = (state_q != S_IDLE);
	assign done                = done_q;
	assign status              = status_q;
	assign match_number        = res_q[RW-1 -: 16];
	assign match_origin        = res_q[RW-17 -: CW];
	assign match_origin_length = res_q[RW-17-CW -: 3];
	assign match_dest          = res_q[18+CW -: CW];
	assign match_dest_length   = res_q[16 +: 3];
	assign match_duration      = res_q[15:0];
	assign last                = last_q;

endmodule

// File: rtl/core/crhi_checker.sv
// ----------------------------------------------------------------------------
// crhi_checker - port-level checks of the record index
// Watches results and handshake of the top level over time.
// ----------------------------------------------------------------------------
module crhi_checker
	import crhi_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [15:0] match_number,
	input logic [2:0] match_origin_length,
	input logic       last
);

	// more results follow a result without last
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> busy || done)
		else $error("block idle after a non-final result");

	// insert answers are single
	a_insert_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_STORED || status == ST_FULL) |-> last)
		else $error("insert result without last");

	// no-match carries an empty payload
	a_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NOMATCH |-> last && match_number == 16'd0
		&& match_origin_length == 3'd0)
		else $error("no-match result with payload");

	// an accepted transaction gets busy or an immediate answer
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || (done && status == ST_FULL))
		else $error("accepted transaction dropped");

endmodule

bind chained_hash_record_index_top crhi_checker u_crhi_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.start               (start),
	.busy                (busy),
	.done                (done),
	.status              (status),
	.match_number        (match_number),
	.match_origin_length (match_origin_length),
	.last                (last)
);
